### rtl/dksr_pkg.sv
// Shared types, constants and helpers of the key set block.
package dksr_pkg;

   localparam int SET_DEPTH   = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int IDX_W       = $clog2(SET_DEPTH);
   localparam int CNT_W       = $clog2(SET_DEPTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W    = 3;
   localparam int IN_KEY_W = 32;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RM_SLOT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RM_KEY   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_CONTAINS,
      OP_RM_SLOT,
      OP_RM_KEY,
      OP_CLEAR,
      OP_REJECT
   } op_kind_type;

   typedef struct packed {
      op_kind_type            kind;
      logic [KEY_WIDTH-1:0]   key;
      logic                   dup_ok;
      logic [SLOT_W-1:0]      slot_index;
   } op_type;

   function automatic logic [KEY_WIDTH-1:0] fit_key(input logic [IN_KEY_W-1:0] k);
      logic [KEY_WIDTH-1:0] r;
      r = '0;
      for (int i = 0; i < KEY_WIDTH; i++) begin
         if (i < IN_KEY_W) begin
            r[i] = k[i];
         end
      end
      return r;
   endfunction

endpackage

### rtl/dksr_if.sv
// Request and response channel interfaces of the key set block.
interface dksr_req_if;
   logic                            valid;
   logic                            ready;
   logic [dksr_pkg::CMD_W-1:0]      command;
   logic [dksr_pkg::IN_KEY_W-1:0]   key;
   logic                            allow_duplicates;
   logic [dksr_pkg::SLOT_W-1:0]     slot_index;

   modport source (output valid, command, key, allow_duplicates, slot_index, input ready);
   modport sink   (input valid, command, key, allow_duplicates, slot_index, output ready);
endinterface

interface dksr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dksr_pkg::STATUS_W-1:0]   status;
   logic [dksr_pkg::SLOT_W-1:0]     slot;
   logic                            added_new;
   logic [dksr_pkg::COUNT_W-1:0]    entry_count;

   modport source (output valid, status, slot, added_new, entry_count, input ready);
   modport sink   (input valid, status, slot, added_new, entry_count, output ready);
endinterface

### rtl/dksr_front.sv
// Front end: decode request words and hold them in a short queue.
module dksr_front (
   input  logic                 clock,
   input  logic                 reset,
   dksr_req_if.sink             req_bus,
   output logic                 head_valid,
   output dksr_pkg::op_type     head_op,
   input  logic                 head_pop
);

   dksr_pkg::op_type                    queue_ff [dksr_pkg::QUEUE_DEPTH];
   logic [dksr_pkg::QPTR_W-1:0]         wr_ptr_ff;
   logic [dksr_pkg::QPTR_W-1:0]         wr_ptr_in;
   logic [dksr_pkg::QPTR_W-1:0]         rd_ptr_ff;
   logic [dksr_pkg::QPTR_W-1:0]         rd_ptr_in;
   logic [dksr_pkg::QCNT_W-1:0]         count_ff;
   logic [dksr_pkg::QCNT_W-1:0]         count_in;
   dksr_pkg::op_type                    dec_op;
   logic                                push;
   logic                                pop;

   always_comb begin
      dec_op.key        = dksr_pkg::fit_key(req_bus.key);
      dec_op.dup_ok     = req_bus.allow_duplicates;
      dec_op.slot_index = req_bus.slot_index;
      case (req_bus.command)
         dksr_pkg::CMD_ADD:      dec_op.kind = dksr_pkg::OP_ADD;
         dksr_pkg::CMD_CONTAINS: dec_op.kind = dksr_pkg::OP_CONTAINS;
         dksr_pkg::CMD_RM_SLOT:  dec_op.kind = dksr_pkg::OP_RM_SLOT;
         dksr_pkg::CMD_RM_KEY: begin
            // reject the null key
            dec_op.kind = (dec_op.key == '0) ? dksr_pkg::OP_REJECT : dksr_pkg::OP_RM_KEY;
         end
         dksr_pkg::CMD_CLEAR:    dec_op.kind = dksr_pkg::OP_CLEAR;
         default:                dec_op.kind = dksr_pkg::OP_REJECT;
      endcase
   end

   assign req_bus.ready = (count_ff != dksr_pkg::QCNT_W'(dksr_pkg::QUEUE_DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign head_valid    = (count_ff != '0);
   assign pop           = head_pop && head_valid;
   assign head_op       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= dec_op;
      end
   end

endmodule

### rtl/dksr_back.sv
// Back end: match against stored keys, update the set, register the response.
module dksr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  dksr_pkg::op_type     head_op,
   output logic                 head_pop,
   dksr_rsp_if.source           rsp_bus
);

   typedef enum logic {
      S_MATCH,
      S_EXEC
   } state_type;

   state_type                               state_ff;
   state_type                               state_in;
   logic [dksr_pkg::KEY_WIDTH-1:0]          keys_ff [dksr_pkg::SET_DEPTH];
   dksr_pkg::op_type                        op_ff;
   logic [dksr_pkg::SET_DEPTH-1:0]          match_ff;
   logic [dksr_pkg::SET_DEPTH-1:0]          match_in;
   logic [dksr_pkg::CNT_W-1:0]              occ_ff;
   logic [dksr_pkg::CNT_W-1:0]              occ_in;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic [dksr_pkg::STATUS_W-1:0]           status_ff;
   logic [dksr_pkg::STATUS_W-1:0]           status_in;
   logic [dksr_pkg::SLOT_W-1:0]             slot_ff;
   logic [dksr_pkg::SLOT_W-1:0]             slot_in;
   logic                                    added_ff;
   logic                                    added_in;

   logic                                    exec_go;
   logic                                    any_match;
   logic [dksr_pkg::IDX_W-1:0]              first_pos;
   logic [dksr_pkg::IDX_W-1:0]              last_pos;
   logic [dksr_pkg::CNT_W-1:0]              occ_dec;
   logic                                    full;
   logic                                    idx_ok;
   logic                                    wr_en;
   logic [dksr_pkg::IDX_W-1:0]              wr_addr;
   logic [dksr_pkg::KEY_WIDTH-1:0]          wr_data;

   assign head_pop = (state_ff == S_MATCH) && head_valid;

   always_comb begin
      for (int i = 0; i < dksr_pkg::SET_DEPTH; i++) begin
         match_in[i] = (dksr_pkg::CNT_W'(i) < occ_ff) && (keys_ff[i] == head_op.key);
      end
   end

   always_comb begin
      first_pos = '0;
      for (int i = dksr_pkg::SET_DEPTH - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            first_pos = dksr_pkg::IDX_W'(i);
         end
      end
   end

   assign any_match = |match_ff;
   assign occ_dec   = occ_ff - 1'b1;
   assign last_pos  = occ_dec[dksr_pkg::IDX_W-1:0];
   assign full      = (occ_ff == dksr_pkg::CNT_W'(dksr_pkg::SET_DEPTH));
   assign idx_ok    = (32'(op_ff.slot_index) < 32'(occ_ff));
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      status_in    = status_ff;
      slot_in      = slot_ff;
      added_in     = added_ff;
      wr_en        = 1'b0;
      wr_addr      = last_pos;
      wr_data      = keys_ff[last_pos];
      case (state_ff)
         S_MATCH: begin
            if (head_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               state_in     = S_MATCH;
               rsp_valid_in = 1'b1;
               status_in    = dksr_pkg::ST_MISS;
               slot_in      = '0;
               added_in     = 1'b0;
               case (op_ff.kind)
                  dksr_pkg::OP_ADD: begin
                     if (!op_ff.dup_ok && any_match) begin
                        status_in = dksr_pkg::ST_OK;
                        slot_in   = dksr_pkg::SLOT_W'(first_pos);
                     end else if (full) begin
                        status_in = dksr_pkg::ST_FULL;
                     end else begin
                        wr_en     = 1'b1;
                        wr_addr   = occ_ff[dksr_pkg::IDX_W-1:0];
                        wr_data   = op_ff.key;
                        occ_in    = occ_ff + 1'b1;
                        status_in = dksr_pkg::ST_OK;
                        slot_in   = dksr_pkg::SLOT_W'(occ_ff);
                        added_in  = 1'b1;
                     end
                  end
                  dksr_pkg::OP_CONTAINS: begin
                     if (any_match) begin
                        status_in = dksr_pkg::ST_OK;
                        slot_in   = dksr_pkg::SLOT_W'(first_pos);
                     end
                  end
                  dksr_pkg::OP_RM_SLOT: begin
                     if (idx_ok) begin
                        wr_en     = 1'b1;
                        wr_addr   = dksr_pkg::IDX_W'(op_ff.slot_index);
                        occ_in    = occ_dec;
                        status_in = dksr_pkg::ST_OK;
                        slot_in   = op_ff.slot_index;
                     end
                  end
                  dksr_pkg::OP_RM_KEY: begin
                     if (any_match) begin
                        wr_en     = 1'b1;
                        wr_addr   = first_pos;
                        occ_in    = occ_dec;
                        status_in = dksr_pkg::ST_OK;
                        slot_in   = dksr_pkg::SLOT_W'(first_pos);
                     end
                  end
                  dksr_pkg::OP_CLEAR: begin
                     occ_in    = '0;
                     status_in = dksr_pkg::ST_OK;
                  end
                  default: begin
                     status_in = dksr_pkg::ST_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_MATCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_MATCH;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      slot_ff   <= slot_in;
      added_ff  <= added_in;
      if (head_pop) begin
         op_ff    <= head_op;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         keys_ff[wr_addr] <= wr_data;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.slot        = slot_ff;
   assign rsp_bus.added_new   = added_ff;
   assign rsp_bus.entry_count = dksr_pkg::COUNT_W'(occ_ff);

endmodule

### rtl/dedup_key_set_swap_remove_top.sv
// A request word passes the queue, the match registers and the response register
// before it leaves as a response word; a busy response register holds it back.
// The back end takes a new word only after the match state and the update state
// of the last one; a 2-entry queue decouples request intake.
// Reset: synchronous, active high; empties the set and the queue, drops any
// pending response. Stored keys are not cleared.
module dedup_key_set_swap_remove_top (
   input  logic          clock,
   input  logic          reset,
   dksr_req_if.sink      req_bus,
   dksr_rsp_if.source    rsp_bus
);

   logic                 head_valid;
   logic                 head_pop;
   dksr_pkg::op_type     head_op;

   dksr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .head_valid (head_valid),
      .head_op    (head_op),
      .head_pop   (head_pop)
   );

   dksr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .head_pop   (head_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

### sim/dedup_key_set_swap_remove_top_tb.sv
// Testbench for the key set block: directed and random commands, checked against a predictor.
module dedup_key_set_swap_remove_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;
   localparam int POOL_SIZE   = 6;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES      = 8;

   typedef struct packed {
      logic [dksr_pkg::STATUS_W-1:0] status;
      logic [dksr_pkg::SLOT_W-1:0]   slot;
      logic                          added_new;
      logic [dksr_pkg::COUNT_W-1:0]  entry_count;
   } reply_type;

   class key_set_tracker_type;
      logic [dksr_pkg::KEY_WIDTH-1:0] held_keys[dksr_pkg::SET_DEPTH];
      int                             held_count;
      reply_type                      pending_replies[$];
      int                             mismatches;

      function new();
         held_count = 0;
         mismatches = 0;
      endfunction

      function bit find_key(logic [dksr_pkg::KEY_WIDTH-1:0] k, output int pos);
         pos = 0;
         for (int i = 0; i < held_count; i++) begin
            if (held_keys[i] == k) begin
               pos = i;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void drop_slot(int pos);
         int last;
         last = held_count - 1;
         if (pos != last) begin
            held_keys[pos] = held_keys[last];
         end
         held_count = last;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= SHOW_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
         end
      endfunction

      function void note_command(logic [dksr_pkg::CMD_W-1:0] cmd,
                                 logic [dksr_pkg::IN_KEY_W-1:0] k,
                                 logic dup_ok, logic [dksr_pkg::SLOT_W-1:0] idx);
         reply_type r;
         int        pos;
         bit        hit;
         r.status    = dksr_pkg::ST_MISS;
         r.slot      = '0;
         r.added_new = 1'b0;
         case (cmd)
            dksr_pkg::CMD_ADD: begin
               hit = find_key(k, pos);
               if (!dup_ok && hit) begin
                  r.status = dksr_pkg::ST_OK;
                  r.slot   = pos[dksr_pkg::SLOT_W-1:0];
               end else if (held_count >= dksr_pkg::SET_DEPTH) begin
                  r.status = dksr_pkg::ST_FULL;
               end else begin
                  held_keys[held_count] = k;
                  r.slot      = held_count[dksr_pkg::SLOT_W-1:0];
                  r.status    = dksr_pkg::ST_OK;
                  r.added_new = 1'b1;
                  held_count++;
               end
            end
            dksr_pkg::CMD_CONTAINS: begin
               if (find_key(k, pos)) begin
                  r.status = dksr_pkg::ST_OK;
                  r.slot   = pos[dksr_pkg::SLOT_W-1:0];
               end
            end
            dksr_pkg::CMD_RM_SLOT: begin
               if (int'(idx) < held_count) begin
                  drop_slot(int'(idx));
                  r.status = dksr_pkg::ST_OK;
                  r.slot   = idx;
               end
            end
            dksr_pkg::CMD_RM_KEY: begin
               if (k != '0 && find_key(k, pos)) begin
                  drop_slot(pos);
                  r.status = dksr_pkg::ST_OK;
                  r.slot   = pos[dksr_pkg::SLOT_W-1:0];
               end
            end
            dksr_pkg::CMD_CLEAR: begin
               held_count = 0;
               r.status   = dksr_pkg::ST_OK;
            end
            default: begin
            end
         endcase
         r.entry_count = held_count[dksr_pkg::COUNT_W-1:0];
         pending_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (pending_replies.size() == 0) begin
            flag($sformatf("unexpected response: status %0d slot %0d added %0d count %0d",
                           got.status, got.slot, got.added_new, got.entry_count));
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.slot !== want.slot ||
             got.added_new !== want.added_new || got.entry_count !== want.entry_count) begin
            flag($sformatf({"response mismatch: expected status %0d slot %0d added %0d ",
                            "count %0d, got status %0d slot %0d added %0d count %0d"},
                           want.status, want.slot, want.added_new, want.entry_count,
                           got.status, got.slot, got.added_new, got.entry_count));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm_tail;
   int   stall_left;

   logic [dksr_pkg::IN_KEY_W-1:0] key_pool[POOL_SIZE];
   key_set_tracker_type           tracker = new();

   dksr_req_if req_bus();
   dksr_rsp_if rsp_bus();

   dedup_key_set_swap_remove_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reply_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.status      = rsp_bus.status;
            got.slot        = rsp_bus.slot;
            got.added_new   = rsp_bus.added_new;
            got.entry_count = rsp_bus.entry_count;
            tracker.check_reply(got);
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!calm_tail && $urandom_range(0, 11) == 0) begin
               stall_left = $urandom_range(1, 17);
            end
         end
      end
   end

   // Call at a falling edge; returns at the falling edge after acceptance, or later after a random gap with valid low.
   task automatic send_word(input logic [dksr_pkg::CMD_W-1:0] cmd,
                            input logic [dksr_pkg::IN_KEY_W-1:0] k,
                            input logic dup_ok, input logic [dksr_pkg::SLOT_W-1:0] idx);
      req_bus.command          = cmd;
      req_bus.key              = k;
      req_bus.allow_duplicates = dup_ok;
      req_bus.slot_index       = idx;
      req_bus.valid            = 1'b1;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      tracker.note_command(cmd, k, dup_ok, idx);
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 7) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic drain_replies();
      req_bus.valid = 1'b0;
      while (tracker.pending_replies.size() != 0) @(negedge clock);
   endtask

   function automatic logic [dksr_pkg::IN_KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && tracker.held_count > 0) begin
         return tracker.held_keys[$urandom_range(0, tracker.held_count - 1)];
      end else if (r < 85) begin
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      return $urandom;
   endfunction

   task automatic run_phase(input int n, input int w_add, input int w_rm);
      int                            r;
      logic [dksr_pkg::CMD_W-1:0]    cmd;
      logic [dksr_pkg::SLOT_W-1:0]   idx;
      for (int i = 0; i < POOL_SIZE; i++) begin
         key_pool[i] = $urandom;
      end
      if ($urandom_range(0, 1)) key_pool[0] = '0;
      if ($urandom_range(0, 1)) key_pool[1] = '1;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < w_add) begin
            cmd = dksr_pkg::CMD_ADD;
         end else if (r < w_add + w_rm) begin
            cmd = $urandom_range(0, 1) ? dksr_pkg::CMD_RM_SLOT : dksr_pkg::CMD_RM_KEY;
         end else if (r < 96) begin
            cmd = dksr_pkg::CMD_CONTAINS;
         end else if (r < 98) begin
            cmd = dksr_pkg::CMD_CLEAR;
         end else begin
            cmd = dksr_pkg::CMD_W'($urandom_range(int'(dksr_pkg::CMD_CLEAR) + 1,
                                                  (1 << dksr_pkg::CMD_W) - 1));
         end
         if (tracker.held_count > 0 && $urandom_range(0, 3) != 0) begin
            idx = dksr_pkg::SLOT_W'($urandom_range(0, tracker.held_count - 1));
         end else begin
            idx = dksr_pkg::SLOT_W'($urandom);
         end
         send_word(cmd, pick_key(), 1'($urandom_range(0, 3) == 0), idx);
      end
   endtask

   initial begin
      reset                    = 1'b1;
      calm_tail                = 1'b0;
      req_bus.valid            = 1'b0;
      req_bus.command          = dksr_pkg::CMD_CLEAR;
      req_bus.key              = '0;
      req_bus.allow_duplicates = 1'b0;
      req_bus.slot_index       = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_word(dksr_pkg::CMD_CLEAR, '0, 1'b0, '0);
      send_word(dksr_pkg::CMD_ADD, '0, 1'b0, '0);
      send_word(dksr_pkg::CMD_ADD, '1, 1'b0, '0);
      send_word(dksr_pkg::CMD_ADD, '1, 1'b0, '0);
      send_word(dksr_pkg::CMD_ADD, '1, 1'b1, '1);
      send_word(dksr_pkg::CMD_ADD, '0, 1'b0, '0);
      send_word(dksr_pkg::CMD_CONTAINS, '1, 1'b0, '0);
      send_word(dksr_pkg::CMD_CONTAINS, '0, 1'b1, '0);
      send_word(dksr_pkg::CMD_CONTAINS, 32'h5A5A_5A5A, 1'b0, '0);
      send_word(dksr_pkg::CMD_RM_KEY, '0, 1'b0, '0);
      send_word(dksr_pkg::CMD_RM_KEY, 32'h5A5A_5A5A, 1'b0, '0);
      send_word(dksr_pkg::CMD_RM_SLOT, '0, 1'b0, '1);
      send_word(dksr_pkg::CMD_RM_SLOT, '0, 1'b0, 4'd3);
      send_word(dksr_pkg::CMD_RM_SLOT, '1, 1'b0, 4'd0);
      send_word(dksr_pkg::CMD_RM_KEY, '1, 1'b0, '0);
      for (int c = int'(dksr_pkg::CMD_CLEAR) + 1; c < (1 << dksr_pkg::CMD_W); c++) begin
         send_word(dksr_pkg::CMD_W'(c), '1, 1'b1, '1);
      end
      send_word(dksr_pkg::CMD_ADD, 32'h8000_0001, 1'b1, '0);
      send_word(dksr_pkg::CMD_RM_SLOT, '0, 1'b0, 4'd1);
      send_word(dksr_pkg::CMD_CLEAR, '0, 1'b0, '0);
      send_word(dksr_pkg::CMD_CONTAINS, '0, 1'b0, '0);

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) drain_replies();
         if (p == PHASES - 1) calm_tail = 1'b1;
         case (p % 3)
            0: run_phase(PHASE_ITEMS, 70, 10);
            1: run_phase(PHASE_ITEMS, 30, 50);
            default: run_phase(PHASE_ITEMS, 45, 30);
         endcase
      end

      req_bus.valid = 1'b0;
      while (tracker.pending_replies.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
